/* hdl/ubxtm_pkg.sv */
// ----------------------------------------------------------------------------
// ubxtm_pkg
// Shared types and constants of the time-mark frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxtm_pkg;

    // Frame geometry
    localparam int BUFFER_BYTES_DEF = 40;
    localparam int CHECKED_BYTES    = 30;
    localparam int WALK_BYTES       = CHECKED_BYTES + 2;   // checked bytes plus two check bytes
    localparam int WALK_W           = $clog2(WALK_BYTES);
    localparam int LEN_EXTRA        = 6;

    // Prefix B5 62 0D 03, entry 0 first
    localparam logic [3:0][7:0] PREFIX = {8'h03, 8'h0D, 8'h62, 8'hB5};
    localparam logic [1:0]      PREFIX_LAST = 2'd3;

    // Fletcher sums after class 0x0D and id 0x03
    localparam logic [7:0] CK_A_INIT = 8'h10;
    localparam logic [7:0] CK_B_INIT = 8'h1D;

    // Byte offsets in the stored frame
    localparam int OFS_CHAN  = 2;
    localparam int OFS_FLAGS = 3;
    localparam int OFS_WEEK  = 6;
    localparam int OFS_MS    = 10;
    localparam int OFS_NS    = 14;
    localparam int OFS_ACC   = 26;

    // Register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_INTERVAL     = 2'd0;
    localparam logic [1:0]  CFG_VALID_MASK   = 2'd1;
    localparam logic [1:0]  CFG_RISING_MASK  = 2'd2;
    localparam int          CFG_DATA_W       = 32;

    // Register reset values
    localparam logic [31:0] INTERVAL_RST    = 32'd5000;
    localparam logic [7:0]  VALID_MASK_RST  = 8'h40;
    localparam logic [7:0]  RISING_MASK_RST = 8'h80;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_CKSUM     = 2'd1;
    localparam logic [1:0] STAT_NOT_VALID = 2'd2;
    localparam logic [1:0] STAT_MISMATCH  = 2'd3;

    typedef struct packed {
        logic              take;      // input word accepted this cycle
        logic              rd_en;     // frame store read issue
        logic [WALK_W-1:0] rd_addr;
        logic              load_res;  // load result register, update history
    } t_cmd;

    typedef struct packed {
        logic complete;               // accepted word closes a frame
    } t_sts;

endpackage

`default_nettype wire

/* hdl/ubxtm_ifs.sv */
// ----------------------------------------------------------------------------
// ubxtm channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubxtm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       clear_history;
    modport source (output valid, rx_byte, clear_history, input ready);
    modport sink   (input valid, rx_byte, clear_history, output ready);
endinterface

interface ubxtm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] mark_ns;
    logic [31:0] accuracy_ns;
    modport source (output valid, status, mark_ns, accuracy_ns, input ready);
    modport sink   (input valid, status, mark_ns, accuracy_ns, output ready);
endinterface

interface ubxtm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ubxtm_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [ubxtm_pkg::CFG_DATA_W-1:0]     cfg_data;
    modport source (output valid, cfg_index, cfg_data, input ready);
    modport sink   (input valid, cfg_index, cfg_data, output ready);
endinterface

`default_nettype wire

/* hdl/ubx_time_mark_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// ubx_time_mark_frame_parser_core
// Hunts TIM-TM2 frames in a byte stream, checks them and reports time marks.
// ----------------------------------------------------------------------------
//  port    dir  word                                      handshake
//  i_rx    in   rx_byte[7:0], clear_history               valid/ready
//  o_res   out  status[1:0], mark_ns[31:0], accuracy_ns   valid/ready
//  i_cfg   in   cfg_index[1:0], cfg_data[31:0]            valid/ready (ready=1)
//
//  A closing byte starts a sequence: intake, 32 reads of the frame store
//  through its single read port for the Fletcher walk, a drain, a result load.
//  The result load waits while the previous result is still untaken.
//  Synchronous active-low reset; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_time_mark_frame_parser_core #(
    parameter int BUFFER_BYTES = ubxtm_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ubxtm_byte_if.sink      i_rx,
    ubxtm_res_if.source     o_res,
    ubxtm_cfg_if.sink       i_cfg
);

    ubxtm_pkg::t_cmd w_cmd;
    ubxtm_pkg::t_sts w_sts;
    logic            w_in_ready;
    logic            w_out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;

    ubxtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ubxtm_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_rx_byte       (i_rx.rx_byte),
        .i_clear_history (i_rx.clear_history),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.cfg_index),
        .i_cfg_data      (i_cfg.cfg_data),
        .o_status        (o_res.status),
        .o_mark_ns       (o_res.mark_ns),
        .o_accuracy_ns   (o_res.accuracy_ns)
    );

endmodule

`default_nettype wire

/* hdl/ubxtm_ram.sv */
// ----------------------------------------------------------------------------
// ubxtm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/ubxtm_ctrl.sv */
// ----------------------------------------------------------------------------
// ubxtm_ctrl
// Sequencer: byte intake, checksum walk over the frame store, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxtm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire ubxtm_pkg::t_sts  i_sts,
    output ubxtm_pkg::t_cmd       o_cmd
);

    localparam int WW = ubxtm_pkg::WALK_W;

    localparam logic [1:0] S_RECV   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    localparam logic [WW-1:0] WALK_LAST = WW'(ubxtm_pkg::WALK_BYTES - 1);

    logic [1:0]    r_state, n_state;
    logic [WW-1:0] r_walk,  n_walk;
    logic          r_out_vld, n_out_vld;
    logic          w_out_free;

    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_walk    = r_walk;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_RECV: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_sts.complete) begin
                    n_state = S_WALK;
                    n_walk  = '0;
                end
            end
            S_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_walk;
                n_walk        = r_walk + 1'b1;
                if (r_walk == WALK_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word is folded in at the end of this cycle
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_res) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RECV;
            r_walk    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_walk    <= n_walk;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_res |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an untaken word");

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.complete) |=> (r_state == S_WALK && r_walk == '0))
        else $error("frame completion did not start the walk");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_walk == WALK_LAST) |=> ##1 (r_state == S_RESULT))
        else $error("walk did not reach the result state");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> !$past(o_cmd.take))
        else $error("byte taken during walk");

endmodule

`default_nettype wire

/* hdl/ubxtm_dp.sv */
// ----------------------------------------------------------------------------
// ubxtm_dp
// Datapath: prefix hunt, frame store, Fletcher-8 sums, field checks, history.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxtm_dp #(
    parameter int BUFFER_BYTES = ubxtm_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ubxtm_pkg::t_cmd                     i_cmd,
    output ubxtm_pkg::t_sts                          o_sts,
    input  wire logic [7:0]                          i_rx_byte,
    input  wire logic                                i_clear_history,
    input  wire logic                                i_cfg_we,
    input  wire logic [ubxtm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ubxtm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic      [1:0]                          o_status,
    output logic      [31:0]                         o_mark_ns,
    output logic      [31:0]                         o_accuracy_ns
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int WW = ubxtm_pkg::WALK_W;

    localparam logic [FW-1:0] FILL_FULL = FW'(BUFFER_BYTES);
    localparam logic [WW-1:0] I_CK_A  = WW'(ubxtm_pkg::CHECKED_BYTES);
    localparam logic [WW-1:0] I_CK_B  = WW'(ubxtm_pkg::CHECKED_BYTES + 1);
    localparam logic [WW-1:0] I_CHAN  = WW'(ubxtm_pkg::OFS_CHAN);
    localparam logic [WW-1:0] I_FLAGS = WW'(ubxtm_pkg::OFS_FLAGS);
    localparam logic [WW-1:0] I_WEEK  = WW'(ubxtm_pkg::OFS_WEEK);
    localparam logic [WW-1:0] I_MS    = WW'(ubxtm_pkg::OFS_MS);
    localparam logic [WW-1:0] I_NS    = WW'(ubxtm_pkg::OFS_NS);
    localparam logic [WW-1:0] I_ACC   = WW'(ubxtm_pkg::OFS_ACC);

    // control state
    logic [1:0]              r_pfx;
    logic                    r_armed;
    logic [FW-1:0]           r_fill;
    logic [BUFFER_BYTES-1:0] r_vld;
    logic [31:0]             r_prev_ms;
    logic [15:0]             r_prev_week;
    logic [31:0]             r_interval;
    logic [7:0]              r_vmask;
    logic [7:0]              r_rmask;

    // payload
    logic [7:0]    r_len;
    logic          r_rd_live;
    logic [WW-1:0] r_rd_idx;
    logic          r_rd_ok;
    logic [7:0]    r_ca, r_cb, r_ck_a, r_ck_b;
    logic [7:0]    r_chan, r_flags;
    logic [15:0]   r_week;
    logic [31:0]   r_ms, r_ns, r_acc;
    logic [1:0]    r_status;
    logic [31:0]   r_out_ns, r_out_acc;

    logic [FW-1:0] w_fill_nx;
    logic [7:0]    w_len_nx;
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_q, w_d, w_ca_nx;
    logic          w_sum_ok, w_qualify, w_time_ok;
    logic [7:0]    w_both, w_f;
    logic [1:0]    w_status;

    // ---- intake ----
    assign w_fill_nx = r_fill + 1'b1;
    assign w_len_nx  = (r_fill == '0) ? i_rx_byte : r_len;
    assign w_we      = i_cmd.take && r_armed;
    assign o_sts.complete = r_armed && (9'(w_fill_nx) >= (9'(w_len_nx) + 9'(ubxtm_pkg::LEN_EXTRA)));

    assign w_raddr = AW'(i_cmd.rd_addr);

    ubxtm_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // never-written entries read as zero
    assign w_d     = r_rd_ok ? w_q : 8'h00;
    assign w_ca_nx = r_ca + w_d;

    // ---- checks ----
    assign w_sum_ok  = (r_ca == r_ck_a) && (r_cb == r_ck_b);
    assign w_both    = r_vmask | r_rmask;
    assign w_f       = r_flags & w_both;
    assign w_qualify = (w_f == w_both) && (r_chan == 8'h00);
    assign w_time_ok = w_qualify && (r_week == r_prev_week) &&
                       (r_ms == r_prev_ms + r_interval);

    always_comb begin
        if (!w_sum_ok) begin
            w_status = ubxtm_pkg::STAT_CKSUM;
        end else if (w_time_ok) begin
            w_status = ubxtm_pkg::STAT_OK;
        end else if ((w_f & r_vmask) != 8'h00) begin
            w_status = ubxtm_pkg::STAT_MISMATCH;
        end else begin
            w_status = ubxtm_pkg::STAT_NOT_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx       <= '0;
            r_armed     <= 1'b0;
            r_fill      <= '0;
            r_vld       <= '0;
            r_prev_ms   <= '1;
            r_prev_week <= '1;
            r_interval  <= ubxtm_pkg::INTERVAL_RST;
            r_vmask     <= ubxtm_pkg::VALID_MASK_RST;
            r_rmask     <= ubxtm_pkg::RISING_MASK_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ubxtm_pkg::CFG_INTERVAL:    r_interval <= i_cfg_data;
                    ubxtm_pkg::CFG_VALID_MASK:  r_vmask    <= i_cfg_data[7:0];
                    ubxtm_pkg::CFG_RISING_MASK: r_rmask    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                if (i_clear_history) begin
                    r_prev_ms   <= '1;
                    r_prev_week <= '1;
                end
                if (r_armed) begin
                    r_vld[r_fill[AW-1:0]] <= 1'b1;
                    r_fill <= w_fill_nx;
                    if (o_sts.complete || w_fill_nx >= FILL_FULL) begin
                        r_armed <= 1'b0;
                    end
                end else if (ubxtm_pkg::PREFIX[r_pfx] == i_rx_byte) begin
                    if (r_pfx == ubxtm_pkg::PREFIX_LAST) begin
                        r_armed <= 1'b1;
                        r_fill  <= '0;
                        r_pfx   <= '0;
                    end else begin
                        r_pfx <= r_pfx + 1'b1;
                    end
                end else begin
                    r_pfx <= '0;
                end
            end
            if (i_cmd.load_res && w_sum_ok && w_qualify) begin
                r_prev_ms   <= r_ms;
                r_prev_week <= r_week;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_live <= i_cmd.rd_en;
        r_rd_idx  <= i_cmd.rd_addr;
        r_rd_ok   <= r_vld[w_raddr];
        if (w_we && r_fill == '0) begin
            r_len <= i_rx_byte;
        end
        if (i_cmd.take) begin
            r_ca <= ubxtm_pkg::CK_A_INIT;
            r_cb <= ubxtm_pkg::CK_B_INIT;
        end
        if (r_rd_live) begin
            if (r_rd_idx < I_CK_A) begin
                r_ca <= w_ca_nx;
                r_cb <= r_cb + w_ca_nx;
            end
            if (r_rd_idx == I_CK_A)  r_ck_a  <= w_d;
            if (r_rd_idx == I_CK_B)  r_ck_b  <= w_d;
            if (r_rd_idx == I_CHAN)  r_chan  <= w_d;
            if (r_rd_idx == I_FLAGS) r_flags <= w_d;
            // little-endian fields shift in from the top
            if (r_rd_idx >= I_WEEK && r_rd_idx < I_WEEK + WW'(2)) begin
                r_week <= {w_d, r_week[15:8]};
            end
            if (r_rd_idx >= I_MS && r_rd_idx < I_MS + WW'(4)) begin
                r_ms <= {w_d, r_ms[31:8]};
            end
            if (r_rd_idx >= I_NS && r_rd_idx < I_NS + WW'(4)) begin
                r_ns <= {w_d, r_ns[31:8]};
            end
            if (r_rd_idx >= I_ACC && r_rd_idx < I_ACC + WW'(4)) begin
                r_acc <= {w_d, r_acc[31:8]};
            end
        end
        if (i_cmd.load_res) begin
            r_status  <= w_status;
            r_out_ns  <= (w_status == ubxtm_pkg::STAT_OK) ? r_ns  : 32'd0;
            r_out_acc <= (w_status == ubxtm_pkg::STAT_OK) ? r_acc : 32'd0;
        end
    end

    assign o_status      = r_status;
    assign o_mark_ns     = r_out_ns;
    assign o_accuracy_ns = r_out_acc;

endmodule

`default_nettype wire
